// ===== src/mvaa_pkg.sv =====
// Shared types and constants of the mixed Voronoi area accumulator.
`timescale 1ns / 1ps
package mvaa_pkg;

  localparam int DEF_NODES = 1024;
  localparam int NODE_W    = 10;
  localparam int COORD_W   = 24;
  localparam int AREA_W    = 48;
  localparam int PROD_W    = 98;   // dot * squared length
  localparam int DEN_W     = 53;   // 8 * |doubled area|
  localparam int DIV_STEPS = 48;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_C1, S_C2, S_C3, S_C4, S_DECIDE, S_TERM, S_MUL, S_MFLUSH,
    S_DIV_GO, S_DIV_WAIT, S_NRD, S_NWR, S_RRD, S_RESP
  } state_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       decide;
    logic       mul_clear;
    logic       mul_step;
    logic       div_start;
    logic       node_wr;
    logic       respond;
    logic [1:0] term;
    logic [1:0] node;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic degen;
    logic obtuse;
    logic skip;
    logic mul_last;
    logic div_done;
  } stat_t;

endpackage

// ===== src/mvaa_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating at 48 bits.
`timescale 1ns / 1ps
module mvaa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mvaa_pkg::PROD_W-1:0]   num,
  input  logic [mvaa_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [mvaa_pkg::AREA_W-1:0]   quo,
  output logic                          sat
);
  import mvaa_pkg::*;

  localparam int HI_W = PROD_W - AREA_W;

  logic                run;
  logic [5:0]          cnt;
  logic [DEN_W-1:0]    rem;
  logic [AREA_W-1:0]   low;
  logic [HI_W-1:0]     num_hi;
  logic [DEN_W:0]      trial;
  logic                ge;

  assign num_hi = num[PROD_W-1:AREA_W];
  assign trial  = {rem, low[AREA_W-1]};
  assign ge     = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sat <= 1'b0;
        if (den == '0) begin
          quo  <= '0;
          done <= 1'b1;
        end else if ({{(DEN_W-HI_W){1'b0}}, num_hi} >= den) begin
          // quotient needs more than 48 bits: clamp at once
          quo  <= AREA_MAX;
          sat  <= 1'b1;
          done <= 1'b1;
        end else begin
          rem <= DEN_W'(num_hi);
          low <= num[AREA_W-1:0];
          quo <= '0;
          cnt <= 6'(DIV_STEPS);
          run <= 1'b1;
        end
      end else if (run) begin
        rem <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        low <= {low[AREA_W-2:0], 1'b0};
        quo <= {quo[AREA_W-2:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/mvaa_ctrl.sv =====
// Sequencer for the area accumulator.
`timescale 1ns / 1ps
module mvaa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  mvaa_pkg::stat_t stat,
  output mvaa_pkg::cmd_t  cmd
);
  import mvaa_pkg::*;

  state_t     state, state_next;
  logic [1:0] term, term_next;
  logic [1:0] node, node_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      term  <= '0;
      node  <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
      node  <= node_next;
    end
  end

  always_comb begin
    state_next = state;
    term_next  = term;
    node_next  = node;
    case (state)
      S_CLEAR:  if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_C1;
      S_C1: begin
        node_next  = '0;
        state_next = stat.is_read ? S_RRD : S_C2;
      end
      S_C2:     state_next = S_C3;
      S_C3:     state_next = S_C4;
      S_C4:     state_next = S_DECIDE;
      S_DECIDE: begin
        term_next = '0;
        if (stat.degen)       state_next = S_RESP;
        else if (stat.obtuse) state_next = S_NRD;
        else                  state_next = S_TERM;
      end
      S_TERM: begin
        if (!stat.skip)        state_next = S_MUL;
        else if (term == 2'd2) state_next = S_NRD;
        else                   term_next  = term + 2'd1;
      end
      S_MUL:    if (stat.mul_last) state_next = S_MFLUSH;
      S_MFLUSH: state_next = S_DIV_GO;
      S_DIV_GO: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          if (term == 2'd2) begin
            state_next = S_NRD;
          end else begin
            term_next  = term + 2'd1;
            state_next = S_TERM;
          end
        end
      end
      S_NRD:    state_next = S_NWR;
      S_NWR: begin
        if (node == 2'd2) begin
          state_next = S_RESP;
        end else begin
          node_next  = node + 2'd1;
          state_next = S_NRD;
        end
      end
      S_RRD:    state_next = S_RESP;
      S_RESP:   state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.term = term;
    cmd.node = node;
    busy     = (state != S_IDLE);
    case (state)
      S_CLEAR:  cmd.clear     = 1'b1;
      S_IDLE:   cmd.load      = start;
      S_DECIDE: cmd.decide    = 1'b1;
      S_TERM:   cmd.mul_clear = !stat.skip;
      S_MUL:    cmd.mul_step  = 1'b1;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_NWR:    cmd.node_wr   = 1'b1;
      S_RESP:   cmd.respond   = 1'b1;
      default:  cmd.load      = 1'b0;
    endcase
  end

endmodule

// ===== src/mvaa_dp.sv =====
// Datapath: geometry stages, long multiply, divider, node area memory.
`timescale 1ns / 1ps
module mvaa_dp #(
  parameter int NODES = mvaa_pkg::DEF_NODES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mvaa_pkg::cmd_t                      cmd,
  output mvaa_pkg::stat_t                     stat,
  input  logic                                cfg_we,
  input  logic [mvaa_pkg::AREA_W-1:0]         cfg_data,
  input  logic                                operation,
  input  logic [mvaa_pkg::NODE_W-1:0]         node_a,
  input  logic [mvaa_pkg::NODE_W-1:0]         node_b,
  input  logic [mvaa_pkg::NODE_W-1:0]         node_c,
  input  logic signed [mvaa_pkg::COORD_W-1:0] ax,
  input  logic signed [mvaa_pkg::COORD_W-1:0] ay,
  input  logic signed [mvaa_pkg::COORD_W-1:0] bx,
  input  logic signed [mvaa_pkg::COORD_W-1:0] by_coord,
  input  logic signed [mvaa_pkg::COORD_W-1:0] cx,
  input  logic signed [mvaa_pkg::COORD_W-1:0] cy,
  output logic                                done,
  output logic [1:0]                          status,
  output logic [mvaa_pkg::AREA_W-1:0]         tri_area_out,
  output logic [mvaa_pkg::AREA_W-1:0]         node_area_out
);
  import mvaa_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DW = COORD_W + 1;
  localparam int PW = 2 * DW;

  // configuration and captured request
  logic [AREA_W-1:0] area_floor;
  logic              op;
  logic [NODE_W-1:0] na, nb, nc;
  logic signed [COORD_W-1:0] x0, y0, x1, y1, x2, y2;

  always_ff @(posedge clk) begin
    if (rst) area_floor <= '0;
    else if (cfg_we) area_floor <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      na <= node_a; nb <= node_b; nc <= node_c;
      x0 <= ax; y0 <= ay; x1 <= bx; y1 <= by_coord; x2 <= cx; y2 <= cy;
    end
  end

  // stage 1: edges
  logic signed [DW-1:0] abx, aby, acx, acy, bcx, bcy;
  always_ff @(posedge clk) begin
    abx <= DW'(x1) - DW'(x0); aby <= DW'(y1) - DW'(y0);
    acx <= DW'(x2) - DW'(x0); acy <= DW'(y2) - DW'(y0);
    bcx <= DW'(x2) - DW'(x1); bcy <= DW'(y2) - DW'(y1);
  end

  // stage 2: products
  logic signed [PW-1:0] p_cr0, p_cr1, p_bcx, p_bcy, p_acx, p_acy, p_abx, p_aby;
  logic signed [PW-1:0] p_da0, p_da1, p_db0, p_db1, p_dc0, p_dc1;
  always_ff @(posedge clk) begin
    p_cr0 <= abx * acy; p_cr1 <= aby * acx;
    p_bcx <= bcx * bcx; p_bcy <= bcy * bcy;
    p_acx <= acx * acx; p_acy <= acy * acy;
    p_abx <= abx * abx; p_aby <= aby * aby;
    p_da0 <= abx * acx; p_da1 <= aby * acy;
    p_db0 <= abx * bcx; p_db1 <= aby * bcy;
    p_dc0 <= acx * bcx; p_dc1 <= acy * bcy;
  end

  // stage 3: sums
  logic signed [PW:0] a2, dot_a, dot_b, dot_c;
  logic [48:0]        la2, lb2, lc2;
  always_ff @(posedge clk) begin
    a2    <= (PW+1)'(p_cr0) - (PW+1)'(p_cr1);
    la2   <= 49'(p_bcx[47:0]) + 49'(p_bcy[47:0]);
    lb2   <= 49'(p_acx[47:0]) + 49'(p_acy[47:0]);
    lc2   <= 49'(p_abx[47:0]) + 49'(p_aby[47:0]);
    dot_a <= (PW+1)'(p_da0) + (PW+1)'(p_da1);
    dot_b <= -((PW+1)'(p_db0) + (PW+1)'(p_db1));
    dot_c <= (PW+1)'(p_dc0) + (PW+1)'(p_dc1);
  end

  // stage 4: area, class of triangle
  logic [49:0]      abs_a2;
  logic [48:0]      area;
  logic [DEN_W-1:0] den;
  logic             ob_a, ob_b, ob_c, degen;
  always_ff @(posedge clk) begin
    abs_a2 <= a2[PW] ? 50'(-a2) : 50'(a2);
    ob_a   <= {1'b0, la2} > ({1'b0, lb2} + {1'b0, lc2});
    ob_b   <= {1'b0, lb2} > ({1'b0, la2} + {1'b0, lc2});
    ob_c   <= {1'b0, lc2} > ({1'b0, la2} + {1'b0, lb2});
  end
  assign area  = abs_a2[49:1];
  assign den   = {abs_a2, 3'b000};
  assign degen = area < {1'b0, area_floor};

  // long multiply: four 25x25 partial products, registered before the add
  logic [48:0]       mx, my;
  logic [1:0]        mk, pp_k;
  logic [DW-1:0]     mxs, mys;
  logic [PW-1:0]     pp;
  logic              pp_vld;
  logic [PROD_W-1:0] acc, pp_sh;

  always_comb begin
    case (cmd.term)
      2'd0:    begin mx = dot_a[48:0]; my = la2; end
      2'd1:    begin mx = dot_b[48:0]; my = lb2; end
      default: begin mx = dot_c[48:0]; my = lc2; end
    endcase
    mxs = mk[1] ? DW'(mx[48:DW]) : mx[DW-1:0];
    mys = mk[0] ? DW'(my[48:DW]) : my[DW-1:0];
    case (pp_k)
      2'd0:    pp_sh = PROD_W'(pp);
      2'd3:    pp_sh = PROD_W'(pp) << (2 * DW);
      default: pp_sh = PROD_W'(pp) << DW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_clear) begin
      acc    <= '0;
      mk     <= '0;
      pp_vld <= 1'b0;
    end else begin
      pp_vld <= cmd.mul_step;
      if (cmd.mul_step) begin
        pp   <= mxs * mys;
        pp_k <= mk;
        mk   <= mk + 2'd1;
      end
      if (pp_vld) acc <= acc + pp_sh;
    end
  end

  logic              skip;
  logic signed [PW:0] dot_sel;
  always_comb begin
    case (cmd.term)
      2'd0:    dot_sel = dot_a;
      2'd1:    dot_sel = dot_b;
      default: dot_sel = dot_c;
    endcase
    skip = dot_sel[PW] || (dot_sel == '0) || (abs_a2 == '0);
  end

  // divider and cotangent terms
  logic              div_done, div_sat;
  logic [AREA_W-1:0] div_quo;
  logic [AREA_W-1:0] t0, t1, t2;
  logic              sat;

  mvaa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (acc),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  // node area memory
  logic [AREA_W-1:0] mem [NODES];
  logic [AREA_W-1:0] rdata, wdata;
  logic [AW-1:0]     raddr, waddr, clr_cnt;
  logic [NODE_W-1:0] nsel;
  logic              in_range, in_range_a, wen, over;
  logic [48:0]       amt;
  logic [49:0]       sum;

  always_comb begin
    case (cmd.node)
      2'd0:    nsel = na;
      2'd1:    nsel = nb;
      default: nsel = nc;
    endcase
    if (ob_a || ob_b || ob_c) begin
      case (cmd.node)
        2'd0:    amt = (ob_a) ? 49'(area[48:1]) : 49'(area[48:2]);
        2'd1:    amt = (!ob_a && ob_b) ? 49'(area[48:1]) : 49'(area[48:2]);
        default: amt = (!ob_a && !ob_b) ? 49'(area[48:1]) : 49'(area[48:2]);
      endcase
    end else begin
      case (cmd.node)
        2'd0:    amt = 49'(t2) + 49'(t1);
        2'd1:    amt = 49'(t2) + 49'(t0);
        default: amt = 49'(t0) + 49'(t1);
      endcase
    end
  end

  assign in_range   = 32'(nsel) < 32'(NODES);
  assign in_range_a = 32'(na) < 32'(NODES);
  assign raddr      = AW'(nsel);
  assign sum        = {2'b00, rdata} + {1'b0, amt};
  assign over       = sum > {2'b00, AREA_MAX};
  assign wen        = cmd.clear || (cmd.node_wr && in_range);
  assign waddr      = cmd.clear ? clr_cnt : raddr;
  assign wdata      = cmd.clear ? '0 : (over ? AREA_MAX : sum[AREA_W-1:0]);

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear) clr_cnt <= clr_cnt + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t0  <= '0; t1 <= '0; t2 <= '0;
      sat <= 1'b0;
    end else begin
      if (cmd.decide && area[48]) sat <= 1'b1;
      if (div_done) begin
        case (cmd.term)
          2'd0:    t0 <= div_quo;
          2'd1:    t1 <= div_quo;
          default: t2 <= div_quo;
        endcase
        if (div_sat) sat <= 1'b1;
      end
      if (cmd.node_wr && in_range && over) sat <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
    if (cmd.respond) begin
      if (op == OP_READ) begin
        status        <= ST_OK;
        tri_area_out  <= '0;
        node_area_out <= in_range_a ? rdata : '0;
      end else begin
        status        <= degen ? ST_DEGEN : (sat ? ST_SAT : ST_OK);
        tri_area_out  <= area[48] ? AREA_MAX : area[AREA_W-1:0];
        node_area_out <= '0;
      end
    end
  end

  assign stat.clear_last = (clr_cnt == AW'(NODES - 1));
  assign stat.is_read    = (op == OP_READ);
  assign stat.degen      = degen;
  assign stat.obtuse     = ob_a || ob_b || ob_c;
  assign stat.skip       = skip;
  assign stat.mul_last   = (mk == 2'd3);
  assign stat.div_done   = div_done;

endmodule

// ===== src/mixed_voronoi_area_accumulator_unit.sv =====
// Top level of the mixed Voronoi control-area accumulator.
`timescale 1ns / 1ps
//
//  channel   | signals                                      | accepted when
//  ----------+----------------------------------------------+------------------
//  request   | start, operation, node_a/b/c, ax..cy          | start && !busy
//  result    | done, status, tri_area_out, node_area_out     | every done cycle
//  config    | cfg_we, cfg_data (smallest accepted area)     | cfg_we
//
//  A read request passes S_C1, S_RRD and S_RESP; done is registered from S_RESP.
//  A degenerate triangle goes through S_C1..S_C4 and S_DECIDE to S_RESP; an
//  obtuse one also reads and writes each of its three nodes. For an acute one
//  each cotangent term has a set-up, a four-step long multiply, a flush, the
//  divider start and a wait on the 48-step one-bit-per-cycle divider; a term
//  with no positive dot product or a zero area is dropped at its set-up.
//  busy falls in the done cycle, so the next request is taken at the edge
//  that ends it.
//  After reset the node store is swept to zero, address by address, while
//  busy is high; configuration writes are taken throughout.
//  The receiver cannot stall: each result stands for one cycle under done.
module mixed_voronoi_area_accumulator_unit #(
  parameter int NODES = mvaa_pkg::DEF_NODES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic [mvaa_pkg::NODE_W-1:0]         node_a,
  input  logic [mvaa_pkg::NODE_W-1:0]         node_b,
  input  logic [mvaa_pkg::NODE_W-1:0]         node_c,
  input  logic signed [mvaa_pkg::COORD_W-1:0] ax,
  input  logic signed [mvaa_pkg::COORD_W-1:0] ay,
  input  logic signed [mvaa_pkg::COORD_W-1:0] bx,
  input  logic signed [mvaa_pkg::COORD_W-1:0] by_coord,
  input  logic signed [mvaa_pkg::COORD_W-1:0] cx,
  input  logic signed [mvaa_pkg::COORD_W-1:0] cy,
  input  logic                                cfg_we,
  input  logic [mvaa_pkg::AREA_W-1:0]         cfg_data,
  output logic                                done,
  output logic [1:0]                          status,
  output logic [mvaa_pkg::AREA_W-1:0]         tri_area_out,
  output logic [mvaa_pkg::AREA_W-1:0]         node_area_out
);
  import mvaa_pkg::*;

  // the controller only steers; all arithmetic and the store sit in the datapath
  cmd_t  cmd;
  stat_t stat;

  mvaa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mvaa_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .node_a        (node_a),
    .node_b        (node_b),
    .node_c        (node_c),
    .ax            (ax),
    .ay            (ay),
    .bx            (bx),
    .by_coord      (by_coord),
    .cx            (cx),
    .cy            (cy),
    .done          (done),
    .status        (status),
    .tri_area_out  (tri_area_out),
    .node_area_out (node_area_out)
  );

endmodule
